### rtl/aerbp_pkg.sv
// ----------------------------------------------------------------------------
// aerbp_pkg
// Shared types and codes for the address-event burst parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package aerbp_pkg;

  // Command codes carried on the input channel.
  localparam logic [1:0] CMD_FEED  = 2'd0;
  localparam logic [1:0] CMD_RESET = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Sticky error flag positions.
  localparam int ERR_TAIL_NO_ROW = 0;
  localparam int ERR_ROW_RANGE   = 1;
  localparam int ERR_COL_RANGE   = 2;
  localparam int ERR_OVERFLOW    = 3;

  // Width of the column count carried in a job (enough for 64 columns).
  localparam int JOB_CNT_W = 7;

  // One job handed from the front end to the back end.
  typedef struct packed {
    logic [JOB_CNT_W-1:0] count;
    logic [5:0]           row;
    logic                 bank;
    logic [3:0]           errors;
    logic [31:0]          bursts;
    logic [31:0]          events;
  } job_t;

  // Bank release notice from the back end once a drain has read its bank.
  typedef struct packed {
    logic valid;
    logic bank;
  } bank_release_t;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EVENT,
    BK_STATUS
  } back_state_t;

endpackage

`default_nettype wire

### rtl/aerbp_ram.sv
// ----------------------------------------------------------------------------
// aerbp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aerbp_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and a read port whose data holds until the next read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/aerbp_queue.sv
// ----------------------------------------------------------------------------
// aerbp_queue
// Two-entry job queue between the front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aerbp_queue
  import aerbp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output job_t      head_job,
  output logic      empty
);

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full     = (fill == 2'd2);
  assign empty    = (fill == 2'd0);
  assign head_job = slots[rd_ptr];

  // Entry storage; no reset needed for payload.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/aerbp_front.sv
// ----------------------------------------------------------------------------
// aerbp_front
// Accepts input beats, runs the burst parser state and queues one job each.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aerbp_front
  import aerbp_pkg::*;
#(
  parameter int INDEX_BITS = 6,
  parameter int ROW_COUNT  = 48,
  parameter int MAX_COLS   = 32,
  parameter int AW         = 5
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [1:0]    command,
  input  wire logic          word_ok,
  input  wire logic          is_tail,
  input  wire logic [7:0]    payload,
  output logic               push,
  output job_t               push_job,
  input  wire logic          queue_full,
  input  wire bank_release_t release_bank,
  output logic               wr_en,
  output logic [AW:0]        wr_addr,
  output logic [5:0]         wr_data
);

  localparam int CNT_W = $clog2(MAX_COLS + 1);

  logic             expecting;
  logic             expecting_next;
  logic [5:0]       current_row;
  logic [5:0]       current_row_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [3:0]       errors;
  logic [3:0]       errors_next;
  logic [31:0]      bursts;
  logic [31:0]      bursts_next;
  logic [31:0]      events;
  logic [31:0]      events_next;
  logic             bank;
  logic             bank_next;
  logic [1:0]       busy;
  logic [1:0]       busy_next;

  logic [INDEX_BITS-1:0] idx;
  logic [7:0]            idx8;
  logic                  room;
  logic                  col_write;
  logic                  accept;
  logic [CNT_W-1:0]      emit_n;

  assign idx  = payload[INDEX_BITS-1:0];
  assign idx8 = 8'(idx);
  assign room = ({1'b0, count} < (CNT_W + 1)'(MAX_COLS));

  // A column write may not touch a bank that is still being drained.
  assign col_write = (command == CMD_FEED) && word_ok && !is_tail && expecting && room;
  assign in_stall  = queue_full || (col_write && busy[bank]);
  assign accept    = in_valid && !in_stall;

  // Parser update for one accepted beat.
  always_comb begin
    expecting_next   = expecting;
    current_row_next = current_row;
    count_next       = count;
    errors_next      = errors;
    bursts_next      = bursts;
    events_next      = events;
    bank_next        = bank;
    busy_next        = busy;
    emit_n           = '0;
    wr_en            = 1'b0;
    wr_addr          = {bank, count[AW-1:0]};
    wr_data          = idx8[5:0];

    if (release_bank.valid) begin
      busy_next[release_bank.bank] = 1'b0;
    end

    if (accept) begin
      case (command)
        CMD_RESET, CMD_CLEAR: begin
          expecting_next   = 1'b0;
          current_row_next = '0;
          count_next       = '0;
          errors_next      = '0;
          if (command == CMD_CLEAR) begin
            bursts_next = '0;
            events_next = '0;
          end
        end
        CMD_FEED: begin
          if (word_ok) begin
            if (is_tail) begin
              if (!expecting) begin
                errors_next[ERR_TAIL_NO_ROW] = 1'b1;
              end else begin
                // Close the burst and hand its bank to the back end.
                emit_n         = count;
                events_next    = events + 32'(count);
                bursts_next    = bursts + 32'd1;
                count_next     = '0;
                expecting_next = 1'b0;
                bank_next      = ~bank;
                if (count != '0) begin
                  busy_next[bank] = 1'b1;
                end
              end
            end else if (!expecting) begin
              current_row_next = idx8[5:0];
              if ({1'b0, idx8} >= 9'(ROW_COUNT)) begin
                errors_next[ERR_ROW_RANGE] = 1'b1;
              end
              count_next     = '0;
              expecting_next = 1'b1;
            end else if (room) begin
              wr_en      = 1'b1;
              count_next = count + CNT_W'(1);
              if ({1'b0, idx8} >= 9'(MAX_COLS)) begin
                errors_next[ERR_COL_RANGE] = 1'b1;
              end
            end else begin
              errors_next[ERR_OVERFLOW] = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Every accepted beat queues one job: errors and totals after the update.
  assign push            = accept;
  assign push_job.count  = JOB_CNT_W'(emit_n);
  assign push_job.row    = current_row;
  assign push_job.bank   = bank;
  assign push_job.errors = errors_next;
  assign push_job.bursts = bursts_next;
  assign push_job.events = events_next;

  // Parser registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      expecting   <= 1'b0;
      current_row <= '0;
      count       <= '0;
      errors      <= '0;
      bursts      <= '0;
      events      <= '0;
      bank        <= 1'b0;
      busy        <= '0;
    end else begin
      expecting   <= expecting_next;
      current_row <= current_row_next;
      count       <= count_next;
      errors      <= errors_next;
      bursts      <= bursts_next;
      events      <= events_next;
      bank        <= bank_next;
      busy        <= busy_next;
    end
  end

endmodule

`default_nettype wire

### rtl/aerbp_back.sv
// ----------------------------------------------------------------------------
// aerbp_back
// Takes jobs from the queue, drains buffered columns and sends the status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aerbp_back
  import aerbp_pkg::*;
#(
  parameter int AW = 5
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        queue_empty,
  input  wire job_t        head_job,
  output logic             pop,
  output logic             rd_en,
  output logic [AW:0]      rd_addr,
  input  wire logic [5:0]  rd_data,
  output bank_release_t    release_bank,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             is_event,
  output logic [5:0]       event_row,
  output logic [5:0]       event_col,
  output logic             last,
  output logic [3:0]       error_bits,
  output logic [31:0]      burst_total,
  output logic [31:0]      event_total
);

  back_state_t          state;
  back_state_t          state_next;
  job_t                 job;
  job_t                 job_next;
  logic [JOB_CNT_W-1:0] pos;
  logic [JOB_CNT_W-1:0] pos_next;
  logic [JOB_CNT_W-1:0] pos_inc;
  logic                 out_free;
  logic                 load_event;
  logic                 load_status;

  assign out_free = !out_valid || !out_stall;
  assign pos_inc  = pos + JOB_CNT_W'(1);

  // Sequencer: one read issued ahead of each event beat.
  always_comb begin
    state_next        = state;
    job_next          = job;
    pos_next          = pos;
    pop               = 1'b0;
    rd_en             = 1'b0;
    rd_addr           = {job.bank, pos_inc[AW-1:0]};
    release_bank      = '0;
    release_bank.bank = job.bank;
    load_event        = 1'b0;
    load_status       = 1'b0;

    case (state)
      BK_IDLE: begin
        if (!queue_empty) begin
          pop      = 1'b1;
          job_next = head_job;
          pos_next = '0;
          if (head_job.count != '0) begin
            rd_en      = 1'b1;
            rd_addr    = {head_job.bank, {AW{1'b0}}};
            state_next = BK_EVENT;
          end else begin
            state_next = BK_STATUS;
          end
        end
      end
      BK_EVENT: begin
        if (out_free) begin
          load_event = 1'b1;
          pos_next   = pos_inc;
          if (pos_inc < job.count) begin
            rd_en = 1'b1;
          end else begin
            release_bank.valid = 1'b1;
            state_next         = BK_STATUS;
          end
        end
      end
      BK_STATUS: begin
        if (out_free) begin
          load_status = 1'b1;
          state_next  = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    job <= job_next;
    pos <= pos_next;
  end

  // Output register; valid is control, the rest is payload.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_event || load_status) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_event || load_status) begin
      is_event    <= load_event;
      event_row   <= load_event ? job.row : 6'd0;
      event_col   <= load_event ? rd_data : 6'd0;
      last        <= load_status;
      error_bits  <= job.errors;
      burst_total <= job.bursts;
      event_total <= job.events;
    end
  end

endmodule

`default_nettype wire

### rtl/aer_burst_event_parser.sv
// ----------------------------------------------------------------------------
// aer_burst_event_parser
// Row/column burst-mode address-event parser with a queued event emitter.
// ----------------------------------------------------------------------------
// Flow: each accepted beat is queued as a job; the back end pops it and, for a
// tail with N buffered columns, gives one event per cycle while out_stall is
// low, then the status beat. The two-entry job queue lets the front end run
// ahead of the back end.
// Reset: synchronous rst clears parser state, counters, queue and output valid.
`timescale 1ns / 1ps
`default_nettype none

module aer_burst_event_parser
  import aerbp_pkg::*;
#(
  parameter int INDEX_BITS = 6,
  parameter int ROW_COUNT  = 48,
  parameter int MAX_COLS   = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  command,
  input  wire logic        word_ok,
  input  wire logic        is_tail,
  input  wire logic [7:0]  payload,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             is_event,
  output logic [5:0]       event_row,
  output logic [5:0]       event_col,
  output logic             last,
  output logic [3:0]       error_bits,
  output logic [31:0]      burst_total,
  output logic [31:0]      event_total
);

  // Address bits within one bank of the double-banked column buffer.
  localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic          push;
  job_t          push_job;
  logic          queue_full;
  logic          pop;
  job_t          head_job;
  logic          queue_empty;
  bank_release_t release_bank;
  logic          wr_en;
  logic [AW:0]   wr_addr;
  logic [5:0]    wr_data;
  logic          rd_en;
  logic [AW:0]   rd_addr;
  logic [5:0]    rd_data;

  // Front end: parser state and column writes.
  aerbp_front #(
    .INDEX_BITS (INDEX_BITS),
    .ROW_COUNT  (ROW_COUNT),
    .MAX_COLS   (MAX_COLS),
    .AW         (AW)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .word_ok      (word_ok),
    .is_tail      (is_tail),
    .payload      (payload),
    .push         (push),
    .push_job     (push_job),
    .queue_full   (queue_full),
    .release_bank (release_bank),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data)
  );

  // Job queue between the two halves.
  aerbp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (queue_full),
    .pop      (pop),
    .head_job (head_job),
    .empty    (queue_empty)
  );

  // Column buffer, two banks so one burst fills while the last one drains.
  aerbp_ram #(
    .WIDTH (6),
    .DEPTH (2 ** (AW + 1))
  ) u_col_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Back end: event drain and status beat.
  aerbp_back #(
    .AW (AW)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .queue_empty  (queue_empty),
    .head_job     (head_job),
    .pop          (pop),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .release_bank (release_bank),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .is_event     (is_event),
    .event_row    (event_row),
    .event_col    (event_col),
    .last         (last),
    .error_bits   (error_bits),
    .burst_total  (burst_total),
    .event_total  (event_total)
  );

endmodule

`default_nettype wire
